### rtl/core/tga_pkg.sv
// ----------------------------------------------------------------------------
// tga_pkg
// shared types and constants of the tga run-length pixel decoder
// ----------------------------------------------------------------------------
package tga_pkg;

    // configuration register indexes
    localparam int CfgIdxW = 2;
    localparam logic [CfgIdxW-1:0] CFG_HAS_ALPHA        = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_RUN_LENGTH_CODED = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_PIXEL_TOTAL      = 2'd2;
    localparam int CfgDataW = 32;

    // byte positions inside a pixel
    localparam logic [1:0] POS_BLUE  = 2'd0;
    localparam logic [1:0] POS_GREEN = 2'd1;
    localparam logic [1:0] POS_RED   = 2'd2;
    localparam logic [1:0] POS_ALPHA = 2'd3;

    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
    localparam logic [7:0] REPEAT_BIAS  = 8'd127;

    typedef struct packed {
        logic        has_alpha;
        logic        run_length_coded;
        logic [31:0] pixel_total;
    } t_cfg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_image;
    } t_byte_item;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [7:0] repeat_count;
        logic       image_done;
        logic       overrun;
    } t_run;

endpackage

### rtl/core/tga_byte_if.sv
// ----------------------------------------------------------------------------
// tga_byte_if
// byte channel into the decoder
// ----------------------------------------------------------------------------
interface tga_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       start_of_image;

    modport source (output valid, output data_byte, output start_of_image, input ready);
    modport sink (input valid, input data_byte, input start_of_image, output ready);
endinterface

### rtl/core/tga_run_if.sv
// ----------------------------------------------------------------------------
// tga_run_if
// pixel run channel out of the decoder
// ----------------------------------------------------------------------------
interface tga_run_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] repeat_count;
    logic       image_done;
    logic       overrun;

    modport source (
        output valid, output red, output green, output blue, output alpha,
        output repeat_count, output image_done, output overrun, input ready
    );
    modport sink (
        input valid, input red, input green, input blue, input alpha,
        input repeat_count, input image_done, input overrun, output ready
    );
endinterface

### rtl/core/tga_in_stage.sv
// ----------------------------------------------------------------------------
// tga_in_stage
// input register, holds one byte transaction for the decode stage
// ----------------------------------------------------------------------------
module tga_in_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    tga_byte_if.sink            i_byte_if,
    input  logic                i_take,
    output logic                o_valid,
    output tga_pkg::t_byte_item o_item
);

    logic                r_valid;
    tga_pkg::t_byte_item r_item;

    assign i_byte_if.ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_byte_if.ready) begin
            r_valid <= i_byte_if.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte_if.ready && i_byte_if.valid) begin
            r_item.data_byte      <= i_byte_if.data_byte;
            r_item.start_of_image <= i_byte_if.start_of_image;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

### rtl/core/tga_decode.sv
// ----------------------------------------------------------------------------
// tga_decode
// per-byte packet parser, pixel assembler and image pixel counter
// ----------------------------------------------------------------------------
module tga_decode (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tga_pkg::t_cfg       i_cfg,
    input  logic                i_valid,
    input  tga_pkg::t_byte_item i_item,
    input  logic                i_out_free,
    output logic                o_take,
    output logic                o_load,
    output tga_pkg::t_run       o_run
);

    logic        r_expect_header;
    logic        r_packet_is_repeat;
    logic [7:0]  r_packet_pixels_left;
    logic [1:0]  r_byte_position;
    logic [23:0] r_color_gathered;
    logic [31:0] r_pixels_left;

    logic        n_expect_header;
    logic        n_packet_is_repeat;
    logic [7:0]  n_packet_pixels_left;
    logic [1:0]  n_byte_position;
    logic [23:0] n_color_gathered;
    logic [31:0] n_pixels_left;

    // state as seen after a possible start of image
    logic        exp_e;
    logic        rep_e;
    logic [7:0]  ppl_e;
    logic [1:0]  pos_e;
    logic [23:0] color_e;
    logic [31:0] pl_e;

    logic [1:0]  last_pos;
    logic [7:0]  byte_in;
    logic [7:0]  cnt;
    logic        ovr;
    logic        hit;
    logic        advance;

    assign advance = i_valid && i_out_free;
    assign byte_in = i_item.data_byte;
    assign last_pos = i_cfg.has_alpha ? tga_pkg::POS_ALPHA : tga_pkg::POS_RED;

    always_comb begin
        exp_e   = i_item.start_of_image ? 1'b1 : r_expect_header;
        rep_e   = i_item.start_of_image ? 1'b0 : r_packet_is_repeat;
        ppl_e   = i_item.start_of_image ? 8'd0 : r_packet_pixels_left;
        pos_e   = i_item.start_of_image ? tga_pkg::POS_BLUE : r_byte_position;
        color_e = i_item.start_of_image ? 24'd0 : r_color_gathered;
        pl_e    = i_item.start_of_image ? i_cfg.pixel_total : r_pixels_left;

        n_expect_header      = exp_e;
        n_packet_is_repeat   = rep_e;
        n_packet_pixels_left = ppl_e;
        n_byte_position      = pos_e;
        n_color_gathered     = color_e;
        n_pixels_left        = pl_e;

        cnt = 8'd1;
        ovr = 1'b0;
        hit = 1'b0;

        if (pl_e == 32'd0) begin
            // nothing left of the image, byte dropped
        end else if (i_cfg.run_length_coded && exp_e) begin
            // packet header
            n_packet_is_repeat   = byte_in[7];
            n_packet_pixels_left = byte_in[7] ? (byte_in - tga_pkg::REPEAT_BIAS)
                                              : (byte_in + 8'd1);
            n_expect_header      = 1'b0;
            n_byte_position      = tga_pkg::POS_BLUE;
        end else if (pos_e < last_pos) begin
            // gather a color byte
            case (pos_e)
                tga_pkg::POS_BLUE:  n_color_gathered[7:0]   = byte_in;
                tga_pkg::POS_GREEN: n_color_gathered[15:8]  = byte_in;
                default:            n_color_gathered[23:16] = byte_in;
            endcase
            n_byte_position = pos_e + 2'd1;
        end else begin
            // pixel complete
            hit             = 1'b1;
            n_byte_position = tga_pkg::POS_BLUE;
            if (!i_cfg.run_length_coded) begin
                n_pixels_left = pl_e - 32'd1;
            end else if (rep_e) begin
                cnt = (ppl_e == 8'd0) ? 8'd1 : ppl_e;
                if ({24'd0, cnt} > pl_e) begin
                    cnt = pl_e[7:0];
                    ovr = 1'b1;
                end
                n_pixels_left        = pl_e - {24'd0, cnt};
                n_packet_pixels_left = 8'd0;
                n_expect_header      = 1'b1;
            end else begin
                n_packet_pixels_left = (ppl_e != 8'd0) ? (ppl_e - 8'd1) : 8'd0;
                n_pixels_left        = pl_e - 32'd1;
                ovr = (n_pixels_left == 32'd0) && (n_packet_pixels_left != 8'd0);
                n_expect_header      = (n_packet_pixels_left == 8'd0);
            end
        end

        o_run.blue         = color_e[7:0];
        o_run.green        = color_e[15:8];
        o_run.red          = i_cfg.has_alpha ? color_e[23:16] : byte_in;
        o_run.alpha        = i_cfg.has_alpha ? byte_in : tga_pkg::ALPHA_OPAQUE;
        o_run.repeat_count = cnt;
        o_run.image_done   = (n_pixels_left == 32'd0);
        o_run.overrun      = ovr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect_header      <= 1'b1;
            r_packet_is_repeat   <= 1'b0;
            r_packet_pixels_left <= 8'd0;
            r_byte_position      <= tga_pkg::POS_BLUE;
            r_color_gathered     <= 24'd0;
            r_pixels_left        <= 32'd0;
        end else if (advance) begin
            r_expect_header      <= n_expect_header;
            r_packet_is_repeat   <= n_packet_is_repeat;
            r_packet_pixels_left <= n_packet_pixels_left;
            r_byte_position      <= n_byte_position;
            r_color_gathered     <= n_color_gathered;
            r_pixels_left        <= n_pixels_left;
        end
    end

    assign o_take = advance;
    assign o_load = advance && hit;

endmodule

### rtl/core/tga_out_stage.sv
// ----------------------------------------------------------------------------
// tga_out_stage
// result register driving the run channel
// ----------------------------------------------------------------------------
module tga_out_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  tga_pkg::t_run i_run,
    output logic          o_free,
    tga_run_if.source     o_run_if
);

    logic          r_valid;
    tga_pkg::t_run r_run;

    assign o_free = !r_valid || o_run_if.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_run <= i_run;
        end
    end

    assign o_run_if.valid        = r_valid;
    assign o_run_if.red          = r_run.red;
    assign o_run_if.green        = r_run.green;
    assign o_run_if.blue         = r_run.blue;
    assign o_run_if.alpha        = r_run.alpha;
    assign o_run_if.repeat_count = r_run.repeat_count;
    assign o_run_if.image_done   = r_run.image_done;
    assign o_run_if.overrun      = r_run.overrun;

endmodule

### rtl/core/tga_rle_pixel_decoder_unit.sv
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder_unit
// tga pixel-data decoder, 24/32 bpp, raw or run-length coded, emits pixel runs
// ----------------------------------------------------------------------------
// One byte transaction is accepted per cycle, sustained, for as long as the
// run channel keeps up. A byte is decoded straight out of the input register,
// and the pixel run that its last byte completes is held in the result
// register, which drives the run channel. Every byte, with or without a
// run, waits in the input register while the result register holds a run that
// the run channel has not taken. The rate is set by the per-byte state update
// of the decode stage (packet header, byte position, 32-bit pixel counter).
// Configuration is taken from the write port at any edge with i_cfg_we high
// and is meant to be changed between images; pixel_total is loaded into the
// pixel counter by the byte that carries start_of_image, and before the
// first such byte every byte is dropped.
// Reset is synchronous and active low and clears all control state.
module tga_rle_pixel_decoder_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [tga_pkg::CfgIdxW-1:0] i_cfg_idx,
    input  logic [tga_pkg::CfgDataW-1:0] i_cfg_data,
    tga_byte_if.sink                    i_byte_if,
    tga_run_if.source                   o_run_if
);

    // configuration registers
    tga_pkg::t_cfg r_cfg;

    // handshake between stages
    logic                in_valid;
    tga_pkg::t_byte_item in_item;
    logic                dec_take;
    logic                dec_load;
    tga_pkg::t_run       dec_run;
    logic                out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.has_alpha        <= 1'b0;
            r_cfg.run_length_coded <= 1'b0;
            r_cfg.pixel_total      <= 32'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tga_pkg::CFG_HAS_ALPHA:        r_cfg.has_alpha        <= i_cfg_data[0];
                tga_pkg::CFG_RUN_LENGTH_CODED: r_cfg.run_length_coded <= i_cfg_data[0];
                tga_pkg::CFG_PIXEL_TOTAL:      r_cfg.pixel_total      <= i_cfg_data[31:0];
                default: begin
                    // writes beyond the register list are dropped
                end
            endcase
        end
    end

    // input register: ready when empty or when the held byte is consumed this cycle
    tga_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte_if (i_byte_if),
        .i_take    (dec_take),
        .o_valid   (in_valid),
        .o_item    (in_item)
    );

    // decode: advances only while the result register can take a run
    tga_decode u_decode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_valid    (in_valid),
        .i_item     (in_item),
        .i_out_free (out_free),
        .o_take     (dec_take),
        .o_load     (dec_load),
        .o_run      (dec_run)
    );

    // result register toward the run channel
    tga_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (dec_load),
        .i_run    (dec_run),
        .o_free   (out_free),
        .o_run_if (o_run_if)
    );

endmodule

### dv/tb_tga_rle_pixel_decoder_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tga_rle_pixel_decoder_unit
// self-checking bench for the tga run-length pixel decoder
// ----------------------------------------------------------------------------
// A short table of directed byte transactions and register writes comes first.
// It covers both pixel widths, raw and coded data, the longest repeat, a run
// cut to fit the image, a literal packet that overruns, a zero-size image, and
// bytes before any image start and after the last pixel. Random phases follow.
// Each phase writes all three registers and streams whole images, broken
// images and noise, under changing idle and stall patterns. Every accepted
// byte goes through a local decoder model, and every pixel run that comes out
// is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_tga_rle_pixel_decoder_unit;

    localparam int unsigned ItemTarget = 1950;
    localparam int unsigned LatencyPad = 8;     // decode pipeline is two deep
    localparam int unsigned HoldCycles = 300;
    localparam int unsigned StallLimit = 3000;
    localparam int unsigned ReportCap  = 40;
    localparam int unsigned SmallImage = 16;
    localparam int unsigned ImageCap   = 20;    // pixels sent of a huge image

    typedef enum logic [1:0] {ROW_WRITE, ROW_BYTE, ROW_PIXEL} t_row_kind;

    typedef struct {
        t_row_kind                   kind;
        logic [tga_pkg::CfgIdxW-1:0] idx;
        logic [31:0]                 value;  // register data, or the byte in [7:0]
        logic                        sof;
        tga_pkg::t_run               run;    // typed-in run for ROW_PIXEL
    } t_row;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_cfg_we;
    logic [tga_pkg::CfgIdxW-1:0]  i_cfg_idx;
    logic [tga_pkg::CfgDataW-1:0] i_cfg_data;

    tga_byte_if byte_if ();
    tga_run_if  run_if ();

    tga_rle_pixel_decoder_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_byte_if  (byte_if),
        .o_run_if   (run_if)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // decoder model: register copy and parse state
    tga_pkg::t_cfg cfg_now;
    logic          want_header;
    logic          repeat_packet;
    logic [7:0]    packet_left;
    logic [1:0]    byte_pos;
    logic [23:0]   color_acc;
    logic [31:0]   image_left;

    tga_pkg::t_run pending_runs[$];
    t_row          directed_rows[$];

    int unsigned   mismatch_count = 0;
    int unsigned   stall_cycles = 0;
    int unsigned   bytes_sent = 0;
    int unsigned   img_bytes;
    logic          img_first;
    int unsigned   tx_idle_pct = 0;
    int unsigned   rx_stall_pct = 0;
    logic          hold_req = 1'b0;
    logic          row_typed = 1'b0;
    tga_pkg::t_run row_run;

    // one byte through the model; returns 1 when it completes a run
    function automatic bit decode_byte(input logic [7:0] data, input logic sof,
                                       output tga_pkg::t_run run);
        logic [1:0] last_pos;
        logic [7:0] cnt;
        run = '0;
        if (sof) begin
            image_left    = cfg_now.pixel_total;
            want_header   = 1'b1;
            repeat_packet = 1'b0;
            packet_left   = '0;
            byte_pos      = tga_pkg::POS_BLUE;
            color_acc     = '0;
        end
        if (image_left == 0) return 1'b0;

        if (cfg_now.run_length_coded && want_header) begin
            // msb set: repeat packet of (header - 127), else literal of header + 1
            repeat_packet = data[7];
            packet_left   = data[7] ? data - tga_pkg::REPEAT_BIAS : data + 8'd1;
            want_header   = 1'b0;
            byte_pos      = tga_pkg::POS_BLUE;
            return 1'b0;
        end

        last_pos = cfg_now.has_alpha ? tga_pkg::POS_ALPHA : tga_pkg::POS_RED;
        if (byte_pos < last_pos) begin
            color_acc[8*byte_pos +: 8] = data;
            byte_pos = byte_pos + 2'd1;
            return 1'b0;
        end

        run.blue  = color_acc[7:0];
        run.green = color_acc[15:8];
        run.red   = cfg_now.has_alpha ? color_acc[23:16] : data;
        run.alpha = cfg_now.has_alpha ? data : tga_pkg::ALPHA_OPAQUE;
        byte_pos  = tga_pkg::POS_BLUE;

        cnt = 8'd1;
        if (!cfg_now.run_length_coded) begin
            image_left = image_left - 1;
        end else if (repeat_packet) begin
            cnt = (packet_left == 0) ? 8'd1 : packet_left;
            if ({24'd0, cnt} > image_left) begin
                // repeat cut at the image end
                cnt = image_left[7:0];
                run.overrun = 1'b1;
            end
            image_left  = image_left - {24'd0, cnt};
            packet_left = '0;
            want_header = 1'b1;
        end else begin
            if (packet_left != 0) packet_left = packet_left - 8'd1;
            image_left = image_left - 1;
            if (image_left == 0 && packet_left != 0) run.overrun = 1'b1;
            if (packet_left == 0) want_header = 1'b1;
        end
        run.repeat_count = cnt;
        run.image_done   = (image_left == 0);
        return 1'b1;
    endfunction

    function automatic tga_pkg::t_run pixel_run(input logic [7:0] r, input logic [7:0] g,
                                                input logic [7:0] b, input logic [7:0] a,
                                                input logic [7:0] cnt, input logic done,
                                                input logic ovr);
        tga_pkg::t_run run;
        run = '{r, g, b, a, cnt, done, ovr};
        return run;
    endfunction

    function automatic t_row row_write(input logic [tga_pkg::CfgIdxW-1:0] idx,
                                       input logic [31:0] value);
        t_row row;
        row.kind  = ROW_WRITE;
        row.idx   = idx;
        row.value = value;
        row.sof   = 1'b0;
        row.run   = '0;
        return row;
    endfunction

    function automatic t_row row_byte(input logic [7:0] data, input logic sof);
        t_row row;
        row.kind  = ROW_BYTE;
        row.idx   = '0;
        row.value = {24'd0, data};
        row.sof   = sof;
        row.run   = '0;
        return row;
    endfunction

    function automatic t_row row_pixel(input logic [7:0] data, input logic sof,
                                       input tga_pkg::t_run run);
        t_row row;
        row      = row_byte(data, sof);
        row.kind = ROW_PIXEL;
        row.run  = run;
        return row;
    endfunction

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= ReportCap)
                $display("%0t run field %s: expected %0d, actual %0d",
                         $time, name, want, got);
        end
    endtask

    task automatic check_run(input tga_pkg::t_run got);
        tga_pkg::t_run want;
        if (pending_runs.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= ReportCap)
                $display("%0t run: expected none, actual %p", $time, got);
            return;
        end
        want = pending_runs.pop_front();
        check_field("red", want.red, got.red);
        check_field("green", want.green, got.green);
        check_field("blue", want.blue, got.blue);
        check_field("alpha", want.alpha, got.alpha);
        check_field("repeat_count", want.repeat_count, got.repeat_count);
        check_field("image_done", {7'd0, want.image_done}, {7'd0, got.image_done});
        check_field("overrun", {7'd0, want.overrun}, {7'd0, got.overrun});
    endtask

    // sampled on the falling edge, where both channels are settled
    always @(negedge i_clk) begin : monitor
        tga_pkg::t_run run;
        tga_pkg::t_run got;
        bit            produced;
        bit            moved;
        if (i_rst_n === 1'b1) begin
            moved = 1'b0;
            if (byte_if.valid && byte_if.ready) begin
                moved = 1'b1;
                produced = decode_byte(byte_if.data_byte, byte_if.start_of_image, run);
                // a typed-in row stands in for the model's run
                if (produced || row_typed)
                    pending_runs.push_back(row_typed ? row_run : run);
            end
            if (run_if.valid && run_if.ready) begin
                moved = 1'b1;
                got = '{run_if.red, run_if.green, run_if.blue, run_if.alpha,
                        run_if.repeat_count, run_if.image_done, run_if.overrun};
                check_run(got);
            end
            stall_cycles = moved ? 0 : stall_cycles + 1;
            if (stall_cycles >= StallLimit) begin
                $display("%0t no transaction for %0d cycles", $time, StallLimit);
                $display("tb_tga_rle_pixel_decoder_unit: errors");
                $finish;
            end
        end
    end

    // run channel ready: random stalls, plus a long hold-off on request
    initial begin : receiver
        int unsigned hold_left;
        hold_left = 0;
        run_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_left = HoldCycles;
                hold_req  = 1'b0;
            end
            if (hold_left != 0) begin
                hold_left--;
                run_if.ready <= 1'b0;
            end else begin
                run_if.ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // one byte transaction; called and returns on a rising edge
    task automatic send_byte(input logic [7:0] data, input logic sof);
        i_cfg_we <= 1'b0;
        while ($urandom_range(99) < tx_idle_pct) begin
            byte_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        byte_if.valid          <= 1'b1;
        byte_if.data_byte      <= data;
        byte_if.start_of_image <= sof;
        do @(negedge i_clk); while (byte_if.ready !== 1'b1);
        @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_img_byte(input logic [7:0] data);
        send_byte(data, img_first);
        img_first = 1'b0;
        img_bytes++;
    endtask

    // sender quiet until every predicted run is out, then let the pipe settle
    task automatic drain_runs();
        byte_if.valid <= 1'b0;
        i_cfg_we      <= 1'b0;
        while (pending_runs.size() != 0) @(posedge i_clk);
        repeat (LatencyPad) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [tga_pkg::CfgIdxW-1:0] idx,
                             input logic [31:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        case (idx)
            tga_pkg::CFG_HAS_ALPHA:        cfg_now.has_alpha = value[0];
            tga_pkg::CFG_RUN_LENGTH_CODED: cfg_now.run_length_coded = value[0];
            tga_pkg::CFG_PIXEL_TOTAL:      cfg_now.pixel_total = value;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // well-formed image with random content, sometimes cut short or padded
    task automatic send_image(input int unsigned px_cap);
        int unsigned px_goal, px_done, px_now, run_len, cut_at, bpp, p, k;
        logic        is_rep;
        px_goal   = (cfg_now.pixel_total < px_cap) ? cfg_now.pixel_total : px_cap;
        cut_at    = ($urandom_range(9) == 0) ? $urandom_range(1, 30) : 32'hFFFF_FFFF;
        bpp       = cfg_now.has_alpha ? 4 : 3;
        img_first = 1'b1;
        img_bytes = 0;
        px_done   = 0;
        // empty image: everything after the start is dropped
        if (px_goal == 0)
            repeat ($urandom_range(1, 4)) send_img_byte(rand_byte());
        while (px_done < px_goal && img_bytes < cut_at) begin
            px_now = 1;
            if (cfg_now.run_length_coded) begin
                case ($urandom_range(15))
                    0: run_len = 128;
                    1, 2: run_len = $urandom_range(1, 128);
                    default: run_len = $urandom_range(1, 6);
                endcase
                is_rep = 1'($urandom_range(1));
                send_img_byte({is_rep, 7'(run_len - 1)});
                if (!is_rep)
                    px_now = (run_len < px_goal - px_done) ? run_len : px_goal - px_done;
                px_done += is_rep ? run_len : px_now;
            end else begin
                px_done++;
            end
            for (p = 0; p < px_now; p++)
                for (k = 0; k < bpp && img_bytes < cut_at; k++)
                    send_img_byte(rand_byte());
        end
        if ($urandom_range(4) == 0)
            repeat ($urandom_range(1, 3)) send_img_byte(rand_byte());
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 12)) send_byte(rand_byte(), $urandom_range(7) == 0);
    endtask

    initial begin : stimulus
        int unsigned phase, img;
        logic [31:0] total;

        i_rst_n                <= 1'b0;
        i_cfg_we               <= 1'b0;
        i_cfg_idx              <= tga_pkg::CFG_HAS_ALPHA;
        i_cfg_data             <= '0;
        byte_if.valid          <= 1'b0;
        byte_if.data_byte      <= '0;
        byte_if.start_of_image <= 1'b0;
        row_run = '0;

        cfg_now.has_alpha        = 1'b0;
        cfg_now.run_length_coded = 1'b0;
        cfg_now.pixel_total      = 32'd1;
        want_header   = 1'b1;
        repeat_packet = 1'b0;
        packet_left   = '0;
        byte_pos      = tga_pkg::POS_BLUE;
        color_acc     = '0;
        image_left    = '0;

        directed_rows = '{
            // no image started yet: dropped
            row_byte(8'h11, 1'b0),
            // raw 24 bpp, one-pixel image, then a byte past the end
            row_byte(8'h00, 1'b1), row_byte(8'h00, 1'b0),
            row_pixel(8'h00, 1'b0, pixel_run(8'h00, 8'h00, 8'h00, tga_pkg::ALPHA_OPAQUE,
                                             8'd1, 1'b1, 1'b0)),
            row_byte(8'hFF, 1'b0),
            // raw 32 bpp, all ones
            row_write(tga_pkg::CFG_HAS_ALPHA, 32'd1),
            row_write(tga_pkg::CFG_PIXEL_TOTAL, 32'd2),
            row_byte(8'hFF, 1'b1), row_byte(8'hFF, 1'b0), row_byte(8'hFF, 1'b0),
            row_pixel(8'hFF, 1'b0, pixel_run(8'hFF, 8'hFF, 8'hFF, 8'hFF,
                                             8'd1, 1'b0, 1'b0)),
            // longest repeat cut to a three-pixel image
            row_write(tga_pkg::CFG_HAS_ALPHA, 32'd0),
            row_write(tga_pkg::CFG_RUN_LENGTH_CODED, 32'd1),
            row_write(tga_pkg::CFG_PIXEL_TOTAL, 32'd3),
            row_byte(8'hFF, 1'b1), row_byte(8'h01, 1'b0), row_byte(8'h02, 1'b0),
            row_pixel(8'h03, 1'b0, pixel_run(8'h03, 8'h02, 8'h01, tga_pkg::ALPHA_OPAQUE,
                                             8'd3, 1'b1, 1'b1)),
            // zero-size image
            row_write(tga_pkg::CFG_PIXEL_TOTAL, 32'd0),
            row_byte(8'h80, 1'b1), row_byte(8'h00, 1'b0),
            // longest literal packet overruns a two-pixel image
            row_write(tga_pkg::CFG_PIXEL_TOTAL, 32'd2),
            row_byte(8'h7F, 1'b1), row_byte(8'h01, 1'b0), row_byte(8'h02, 1'b0),
            row_pixel(8'h03, 1'b0, pixel_run(8'h03, 8'h02, 8'h01, tga_pkg::ALPHA_OPAQUE,
                                             8'd1, 1'b0, 1'b0)),
            row_byte(8'hFC, 1'b0), row_byte(8'hFD, 1'b0),
            row_pixel(8'hFE, 1'b0, pixel_run(8'hFE, 8'hFD, 8'hFC, tga_pkg::ALPHA_OPAQUE,
                                             8'd1, 1'b1, 1'b1)),
            row_byte(8'h55, 1'b0)
        };

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_WRITE) begin
                drain_runs();
                write_reg(directed_rows[i].idx, directed_rows[i].value);
            end else begin
                row_typed = (directed_rows[i].kind == ROW_PIXEL);
                row_run   = directed_rows[i].run;
                send_byte(directed_rows[i].value[7:0], directed_rows[i].sof);
                row_typed = 1'b0;
            end
        end

        phase = 0;
        while (bytes_sent < ItemTarget) begin
            case (phase % 8)
                1: total = 32'd1;
                2: total = 32'hFFFF_FFFF;
                3: total = 32'd4294836225;
                5: total = $urandom();
                6: total = 32'd0;
                default: total = $urandom_range(2, SmallImage);
            endcase
            drain_runs();
            write_reg(tga_pkg::CFG_HAS_ALPHA, 32'($urandom_range(1)));
            write_reg(tga_pkg::CFG_RUN_LENGTH_CODED, 32'($urandom_range(3) != 0));
            write_reg(tga_pkg::CFG_PIXEL_TOTAL, total);

            case (phase % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 73; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 73; end
                default: begin tx_idle_pct = 33; rx_stall_pct = 33; end
            endcase
            // output held off while bytes keep coming: the block must backpressure
            if (phase == 0) hold_req = 1'b1;

            for (img = 0; img < 8 && bytes_sent < ItemTarget; img++) begin
                // sender waits for the pipe to empty in the middle of a phase
                if (phase == 2 && img == 4) drain_runs();
                if ($urandom_range(9) == 0) send_noise();
                else send_image(ImageCap);
            end
            phase++;
        end

        drain_runs();
        if (mismatch_count == 0) begin
            $display("tb_tga_rle_pixel_decoder_unit: clean");
        end else begin
            $display("tb_tga_rle_pixel_decoder_unit: errors");
        end
        $finish;
    end

endmodule

### sim.f
rtl/core/tga_pkg.sv
rtl/core/tga_byte_if.sv
rtl/core/tga_run_if.sv
rtl/core/tga_in_stage.sv
rtl/core/tga_decode.sv
rtl/core/tga_out_stage.sv
rtl/core/tga_rle_pixel_decoder_unit.sv
dv/tb_tga_rle_pixel_decoder_unit.sv
